// ----- src/acpr_pkg.sv -----
package acpr_pkg;

    localparam int unsigned FLASH_FRAMES = 30;
    localparam int unsigned FRAME_CNT_W  = 5;
    localparam int unsigned CFG_INDEX_W  = 1;

    localparam logic [2:0] MODE_SCREEN_ONE = 3'd1;
    localparam logic [2:0] MODE_LINE_ATTR  = 3'd2;
    localparam logic [2:0] MODE_WIDE       = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_INK     = 1'b1;

    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_FRAME = 1'b1;

    typedef enum logic [1:0] {
        LAYOUT_SCREEN_ZERO,
        LAYOUT_SCREEN_ONE,
        LAYOUT_LINE_ATTR,
        LAYOUT_WIDE
    } layout_t;

    typedef struct packed {
        logic [FRAME_CNT_W-1:0] frame_count;
        logic                   flash_phase;
    } flash_status_t;

    typedef struct packed {
        layout_t    layout;
        logic [7:0] line;
        logic [4:0] column;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [3:0] ink;
        logic [3:0] paper;
    } decode_t;

    typedef struct packed {
        logic        wide;
        logic [7:0]  display_row;
        logic [8:0]  x_start;
        logic [13:0] first_addr;
        logic [13:0] second_addr;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [3:0]  ink;
        logic [3:0]  paper;
    } address_t;

    function automatic layout_t decode_layout(input logic [2:0] mode);
        layout_t layout;
        unique case (mode)
            MODE_WIDE:       layout = LAYOUT_WIDE;
            MODE_LINE_ATTR:  layout = LAYOUT_LINE_ATTR;
            MODE_SCREEN_ONE: layout = LAYOUT_SCREEN_ONE;
            default:         layout = LAYOUT_SCREEN_ZERO;
        endcase
        return layout;
    endfunction

    function automatic logic [31:0] expand_single(input logic [7:0] bits,
                                                  input logic [3:0] ink,
                                                  input logic [3:0] paper);
        logic [31:0] result;
        for (int b = 0; b < 8; b++) begin
            result[4*b +: 4] = bits[b] ? ink : paper;
        end
        return result;
    endfunction

    function automatic logic [63:0] expand_double(input logic [7:0] bits,
                                                  input logic [3:0] ink,
                                                  input logic [3:0] paper);
        logic [63:0] result;
        for (int b = 0; b < 8; b++) begin
            result[8*b +: 8] = bits[b] ? {ink, ink} : {paper, paper};
        end
        return result;
    endfunction

endpackage

// ----- src/acpr_flash_timer.sv -----
module acpr_flash_timer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick,
    output acpr_pkg::flash_status_t status
);

    logic [acpr_pkg::FRAME_CNT_W-1:0] frame_count_reg;
    logic [acpr_pkg::FRAME_CNT_W-1:0] frame_count_next;
    logic                             flash_phase_reg;
    logic                             flash_phase_next;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        flash_phase_next = flash_phase_reg;
        if (tick)
        begin
            if (frame_count_reg
                == acpr_pkg::FRAME_CNT_W'(acpr_pkg::FLASH_FRAMES - 1))
            begin
                frame_count_next = '0;
                flash_phase_next = ~flash_phase_reg;
            end
            else
            begin
                frame_count_next = frame_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            flash_phase_reg <= 1'b0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            flash_phase_reg <= flash_phase_next;
        end
    end

    assign status.frame_count = frame_count_reg;
    assign status.flash_phase = flash_phase_reg;

endmodule

// ----- src/acpr_cell_front.sv -----
module acpr_cell_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cell_valid,
    output logic                ready,
    input  logic [2:0]          display_mode,
    input  logic [2:0]          wide_ink,
    input  logic                flash_phase,
    input  logic [7:0]          mem_line,
    input  logic [4:0]          column,
    input  logic [7:0]          first_byte,
    input  logic [7:0]          second_byte,
    output logic                addr_valid,
    input  logic                addr_ready,
    output acpr_pkg::address_t  addr
);

    logic                dec_valid_reg;
    acpr_pkg::decode_t   dec_reg;
    acpr_pkg::decode_t   dec_next;
    logic                addr_valid_reg;
    acpr_pkg::address_t  addr_reg;
    acpr_pkg::address_t  addr_next;
    logic                dec_en;
    logic                addr_en;
    logic [3:0]          attr_ink;
    logic [3:0]          attr_paper;
    logic                screen_one;
    logic [7:0]          row;

    assign addr_en = !addr_valid_reg || addr_ready;
    assign dec_en  = !dec_valid_reg || addr_en;
    assign ready   = dec_en;

    always_comb
    begin
        attr_ink   = {second_byte[6], second_byte[2:0]};
        attr_paper = second_byte[6:3];
        dec_next.layout      = acpr_pkg::decode_layout(display_mode);
        dec_next.line        = mem_line;
        dec_next.column      = column;
        dec_next.first_byte  = first_byte;
        dec_next.second_byte = second_byte;
        if (dec_next.layout == acpr_pkg::LAYOUT_WIDE)
        begin
            dec_next.ink   = {1'b0, wide_ink};
            dec_next.paper = {1'b0, 3'd7 - wide_ink};
        end
        else if (flash_phase && second_byte[7])
        begin
            dec_next.ink   = attr_paper;
            dec_next.paper = attr_ink;
        end
        else
        begin
            dec_next.ink   = attr_ink;
            dec_next.paper = attr_paper;
        end
    end

    always_comb
    begin
        row        = {dec_reg.line[7:6], dec_reg.line[2:0], dec_reg.line[5:3]};
        screen_one = (dec_reg.layout == acpr_pkg::LAYOUT_SCREEN_ONE);
        addr_next.wide        = (dec_reg.layout == acpr_pkg::LAYOUT_WIDE);
        addr_next.display_row = row;
        addr_next.x_start     = {dec_reg.column, 4'b0000};
        addr_next.first_addr  = {screen_one, dec_reg.line, dec_reg.column};
        unique case (dec_reg.layout)
            acpr_pkg::LAYOUT_WIDE, acpr_pkg::LAYOUT_LINE_ATTR:
                addr_next.second_addr = {1'b1, dec_reg.line, dec_reg.column};
            default:
                addr_next.second_addr = {screen_one, 3'b110, row[7:3], dec_reg.column};
        endcase
        addr_next.first_byte  = dec_reg.first_byte;
        addr_next.second_byte = dec_reg.second_byte;
        addr_next.ink         = dec_reg.ink;
        addr_next.paper       = dec_reg.paper;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg  <= 1'b0;
            addr_valid_reg <= 1'b0;
        end
        else
        begin
            if (dec_en)
            begin
                dec_valid_reg <= cell_valid;
            end
            if (addr_en)
            begin
                addr_valid_reg <= dec_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_en && cell_valid)
        begin
            dec_reg <= dec_next;
        end
        if (addr_en && dec_valid_reg)
        begin
            addr_reg <= addr_next;
        end
    end

    assign addr_valid = addr_valid_reg;
    assign addr       = addr_reg;

endmodule

// ----- src/acpr_pixel_stage.sv -----
module acpr_pixel_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               addr_valid,
    output logic               addr_ready,
    input  acpr_pkg::address_t addr,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         display_row,
    output logic [8:0]         x_start,
    output logic [13:0]        first_addr,
    output logic [13:0]        second_addr,
    output logic [63:0]        pixels
);

    logic        out_valid_reg;
    logic        out_en;
    logic [7:0]  display_row_reg;
    logic [8:0]  x_start_reg;
    logic [13:0] first_addr_reg;
    logic [13:0] second_addr_reg;
    logic [63:0] pixels_reg;
    logic [63:0] pixels_next;

    assign out_en     = !out_valid_reg || !out_stall;
    assign addr_ready = out_en;

    always_comb
    begin
        if (addr.wide)
        begin
            pixels_next = {acpr_pkg::expand_single(addr.first_byte, addr.ink, addr.paper),
                           acpr_pkg::expand_single(addr.second_byte, addr.ink, addr.paper)};
        end
        else
        begin
            pixels_next = acpr_pkg::expand_double(addr.first_byte, addr.ink, addr.paper);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= addr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && addr_valid)
        begin
            display_row_reg <= addr.display_row;
            x_start_reg     <= addr.x_start;
            first_addr_reg  <= addr.first_addr;
            second_addr_reg <= addr.second_addr;
            pixels_reg      <= pixels_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign display_row = display_row_reg;
    assign x_start     = x_start_reg;
    assign first_addr  = first_addr_reg;
    assign second_addr = second_addr_reg;
    assign pixels      = pixels_reg;

endmodule

// ----- src/attribute_cell_pixel_renderer.sv -----
// Cell renderer for a character/attribute bitmap display. Each cell request
// (action 0) yields one result on the outputs once it has passed through
// the register stages in turn. The result carries the unscrambled display
// row, x_start, both memory offsets and sixteen 4-bit colours. A new
// request is taken every cycle while in_stall is low; the three register
// stages (attribute decode, address build, pixel expand) each hold one
// request, so throughput is one per cycle while out_stall is low, and
// out_stall backs up into in_stall only once all three stages are full.
// An end-of-frame request (action 1) is consumed at the input, gives no
// result, and toggles the flash phase every 30 frames; cells accepted
// after it see the new phase. Write display_mode and wide_ink only while
// no request is in flight; the configuration port is always ready.
module attribute_cell_pixel_renderer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [acpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [2:0]                       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [7:0]                       mem_line,
    input  logic [4:0]                       column,
    input  logic [7:0]                       first_byte,
    input  logic [7:0]                       second_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       display_row,
    output logic [8:0]                       x_start,
    output logic [13:0]                      first_addr,
    output logic [13:0]                      second_addr,
    output logic [63:0]                      pixels
);

    logic [2:0]              mode_reg;
    logic [2:0]              wide_ink_reg;
    logic                    front_ready;
    logic                    accept;
    logic                    cell_valid;
    logic                    tick;
    logic                    addr_valid;
    logic                    addr_ready;
    acpr_pkg::address_t      addr;
    acpr_pkg::flash_status_t flash_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 3'd0;
            wide_ink_reg <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                acpr_pkg::REG_DISPLAY_MODE: mode_reg     <= cfg_data;
                acpr_pkg::REG_WIDE_INK:     wide_ink_reg <= cfg_data;
                default:                    mode_reg     <= mode_reg;
            endcase
        end
    end

    assign in_stall   = !front_ready;
    assign accept     = in_valid && front_ready;
    assign cell_valid = in_valid && (action == acpr_pkg::ACT_CELL);
    assign tick       = accept && (action == acpr_pkg::ACT_FRAME);

    acpr_flash_timer u_flash_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .status (flash_status)
    );

    acpr_cell_front u_cell_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .ready        (front_ready),
        .display_mode (mode_reg),
        .wide_ink     (wide_ink_reg),
        .flash_phase  (flash_status.flash_phase),
        .mem_line     (mem_line),
        .column       (column),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .addr_valid   (addr_valid),
        .addr_ready   (addr_ready),
        .addr         (addr)
    );

    acpr_pixel_stage u_pixel_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .addr_valid  (addr_valid),
        .addr_ready  (addr_ready),
        .addr        (addr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .display_row (display_row),
        .x_start     (x_start),
        .first_addr  (first_addr),
        .second_addr (second_addr),
        .pixels      (pixels)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        flash_status.frame_count
            < acpr_pkg::FRAME_CNT_W'(acpr_pkg::FLASH_FRAMES))
        else $error("frame counter beyond flash period");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(flash_status.flash_phase)
            |-> $past(tick) && (flash_status.frame_count == '0))
        else $error("flash phase toggled without frame wrap");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && addr_valid)
        else $error("input stalled while pipeline has room");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
            |=> out_valid && $stable(pixels) && $stable(first_addr)
                && $stable(second_addr) && $stable(display_row))
        else $error("stalled result changed");

endmodule

// ----- verif/tb_attribute_cell_pixel_renderer.sv -----
`timescale 1ns / 1ps

module tb_attribute_cell_pixel_renderer;

    typedef struct {
        logic       action;
        logic [7:0] line;
        logic [4:0] column;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } cell_req_t;

    typedef struct {
        logic [7:0]  display_row;
        logic [8:0]  x_start;
        logic [13:0] first_addr;
        logic [13:0] second_addr;
        logic [63:0] pixels;
    } cell_out_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [acpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [2:0]                       cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             action = acpr_pkg::ACT_CELL;
    logic [7:0]                       mem_line = '0;
    logic [4:0]                       column = '0;
    logic [7:0]                       first_byte = '0;
    logic [7:0]                       second_byte = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [7:0]                       display_row;
    logic [8:0]                       x_start;
    logic [13:0]                      first_addr;
    logic [13:0]                      second_addr;
    logic [63:0]                      pixels;

    cell_req_t cell_feed[$];
    cell_out_t rendered_q[$];
    cell_req_t on_wire;
    logic      taken = 1'b0;
    logic      steady = 1'b0;
    int        mismatches = 0;

    logic [2:0]                       cur_mode;
    logic [2:0]                       cur_ink;
    logic [acpr_pkg::FRAME_CNT_W-1:0] frames_seen;
    logic                             flash_on;

    attribute_cell_pixel_renderer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .mem_line    (mem_line),
        .column      (column),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .display_row (display_row),
        .x_start     (x_start),
        .first_addr  (first_addr),
        .second_addr (second_addr),
        .pixels      (pixels)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] paint(input logic [7:0] bits, input logic [3:0] ink,
                                          input logic [3:0] paper, input int reps);
        logic [63:0] p;
        p = '0;
        for (int i = 7; i >= 0; i--)
        begin
            for (int r = 0; r < reps; r++)
            begin
                p = {p[59:0], (bits[i] ? ink : paper)};
            end
        end
        return p;
    endfunction

    function automatic cell_out_t render_cell(input cell_req_t rq);
        cell_out_t          o;
        acpr_pkg::layout_t  lay;
        logic [3:0]         ink;
        logic [3:0]         paper;
        logic [3:0]         swap;
        logic [13:0]        line_off;
        logic [13:0]        scr;
        o.display_row = {rq.line[7:6], rq.line[2:0], rq.line[5:3]};
        o.x_start = {rq.column, 4'b0000};
        line_off = 14'({rq.line, rq.column});
        case (cur_mode)
            acpr_pkg::MODE_WIDE:       lay = acpr_pkg::LAYOUT_WIDE;
            acpr_pkg::MODE_LINE_ATTR:  lay = acpr_pkg::LAYOUT_LINE_ATTR;
            acpr_pkg::MODE_SCREEN_ONE: lay = acpr_pkg::LAYOUT_SCREEN_ONE;
            default:                   lay = acpr_pkg::LAYOUT_SCREEN_ZERO;
        endcase
        if (lay == acpr_pkg::LAYOUT_WIDE)
        begin
            ink = {1'b0, cur_ink};
            paper = 4'd7 - ink;
            o.pixels = (paint(rq.first_byte, ink, paper, 1) << 32)
                     | paint(rq.second_byte, ink, paper, 1);
        end
        else
        begin
            ink = {rq.second_byte[6], rq.second_byte[2:0]};
            paper = {rq.second_byte[6], rq.second_byte[5:3]};
            if (flash_on && rq.second_byte[7])
            begin
                swap = ink;
                ink = paper;
                paper = swap;
            end
            o.pixels = paint(rq.first_byte, ink, paper, 2);
        end
        if (lay == acpr_pkg::LAYOUT_WIDE || lay == acpr_pkg::LAYOUT_LINE_ATTR)
        begin
            o.first_addr = line_off;
            o.second_addr = line_off + 14'h2000;
        end
        else
        begin
            scr = (lay == acpr_pkg::LAYOUT_SCREEN_ONE) ? 14'h2000 : 14'h0000;
            o.first_addr = line_off + scr;
            o.second_addr = 14'({o.display_row[7:3], rq.column}) + 14'h1800 + scr;
        end
        return o;
    endfunction

    function automatic void tick_frame();
        if (frames_seen + 1 >= acpr_pkg::FLASH_FRAMES)
        begin
            frames_seen = '0;
            flash_on = ~flash_on;
        end
        else
        begin
            frames_seen = frames_seen + 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // predict at acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            if (on_wire.action == acpr_pkg::ACT_FRAME)
                tick_frame();
            else
                rendered_q.push_back(render_cell(on_wire));
            taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || taken)
        begin
            taken = 1'b0;
            if ((!steady && $urandom_range(99) < 11) || cell_feed.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                on_wire = cell_feed.pop_front();
                in_valid <= 1'b1;
                action <= on_wire.action;
                mem_line <= on_wire.line;
                column <= on_wire.column;
                first_byte <= on_wire.first_byte;
                second_byte <= on_wire.second_byte;
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 11);
    end

    always @(posedge clk)
    begin : watch_results
        cell_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rendered_q.size() == 0)
            begin
                $error("result with no cell pending");
                mismatches++;
            end
            else
            begin
                want = rendered_q.pop_front();
                check_field("display_row", 64'(want.display_row), 64'(display_row));
                check_field("x_start", 64'(want.x_start), 64'(x_start));
                check_field("first_addr", 64'(want.first_addr), 64'(first_addr));
                check_field("second_addr", 64'(want.second_addr), 64'(second_addr));
                check_field("pixels", want.pixels, pixels);
            end
        end
    end

    task automatic write_config(input logic [2:0] mode, input logic [2:0] ink);
        logic [2:0] vals[2];
        logic [acpr_pkg::CFG_INDEX_W-1:0] idx[2];
        vals = '{mode, ink};
        idx = '{acpr_pkg::REG_DISPLAY_MODE, acpr_pkg::REG_WIDE_INK};
        for (int i = 0; i < 2; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            if (idx[i] == acpr_pkg::REG_DISPLAY_MODE)
                cur_mode = vals[i];
            else
                cur_ink = vals[i];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cell(input logic [7:0] line, input logic [4:0] col,
                             input logic [7:0] b1, input logic [7:0] b2);
        cell_req_t rq;
        rq = '{acpr_pkg::ACT_CELL, line, col, b1, b2};
        cell_feed.push_back(rq);
    endtask

    task automatic push_tick();
        cell_req_t rq;
        rq = '{acpr_pkg::ACT_FRAME, 8'($urandom), 5'($urandom), 8'($urandom),
               8'($urandom)};
        cell_feed.push_back(rq);
    endtask

    // drain all pending cells, then cover pipeline latency
    task automatic drain();
        do
            @(posedge clk);
        while (cell_feed.size() != 0 || in_valid || rendered_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        logic [2:0] mode_plan[10];
        logic [2:0] ink_plan[10];
        int roll;
        int cells;
        mode_plan = '{3'd0, 3'd1, 3'd2, 3'd6, 3'd6, 3'd7, 3'd3, 3'd4, 3'd5, 3'd2};
        ink_plan = '{3'd0, 3'd7, 3'd3, 3'd0, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6, 3'd4};
        cur_mode = '0;
        cur_ink = '0;
        frames_seen = '0;
        flash_on = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_config(3'd0, 3'd0);
        push_cell(8'd0, 5'd0, 8'h00, 8'h00);
        push_cell(8'd191, 5'd31, 8'hFF, 8'hFF);
        push_cell(8'd255, 5'd31, 8'hAA, 8'h55);
        push_cell(8'd7, 5'd1, 8'h55, 8'hAA);
        push_cell(8'd56, 5'd16, 8'h81, 8'h47);
        push_cell(8'd64, 5'd8, 8'hF0, 8'hC7);
        push_tick();
        push_cell(8'd128, 5'd24, 8'h0F, 8'hB8);
        push_cell(8'd63, 5'd3, 8'h3C, 8'h80);
        push_tick();
        push_cell(8'd192, 5'd30, 8'hC3, 8'h7F);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
                write_config(3'($urandom_range(7)), 3'($urandom_range(7)));
            else
                write_config(mode_plan[ph], ink_plan[ph]);
            steady = (ph == 4);
            cells = 0;
            while (cells < ((ph == 4) ? 200 : 120))
            begin
                roll = $urandom_range(99);
                if (roll < 1)
                begin
                    repeat (acpr_pkg::FLASH_FRAMES) push_tick();
                end
                else if (roll < 11)
                begin
                    push_tick();
                end
                else
                begin
                    push_cell((roll < 25) ? 8'($urandom_range(255)) : 8'($urandom_range(191)),
                              5'($urandom_range(31)), 8'($urandom), 8'($urandom));
                    cells++;
                end
            end
            drain();
        end
        steady = 1'b0;

        if (mismatches == 0 && rendered_q.size() == 0)
            $display("attribute_cell_pixel_renderer test passed");
        else
            $display("attribute_cell_pixel_renderer test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("attribute_cell_pixel_renderer test failed");
        $finish;
    end

endmodule
